[design/dual_region_steering_controller_defines.svh]
// assertion macros shared by the steering controller modules
`ifndef DUAL_REGION_STEERING_CONTROLLER_DEFINES_SVH
`define DUAL_REGION_STEERING_CONTROLLER_DEFINES_SVH

// same-cycle implication, checked at every rising edge out of reset
`define DRSC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked at every rising edge out of reset
`define DRSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/drsc_pkg.sv]
// types and constants of the dual region steering controller
`timescale 1ns / 1ps
package drsc_pkg;

  localparam int SENSOR_BITS = 10;

  localparam int DIFF_W  = SENSOR_BITS + 1;
  localparam int DELTA_W = SENSOR_BITS + 2;
  localparam int SUM_W   = SENSOR_BITS + 1;
  localparam int VAL_W   = SENSOR_BITS + 13;
  localparam int POS_W   = 16;
  localparam int THR_W   = 11;
  localparam int DGAIN_W = 8;
  localparam int CMP_W   = (SUM_W > THR_W) ? SUM_W : THR_W;

  localparam int STRAIGHT_MIDDLE_LIMIT = 150;
  localparam int TURN_GAIN_BASE        = 170;
  localparam int STRAIGHT_P            = 6;
  localparam int STRAIGHT_D            = 5;
  localparam int WEAK_LEVEL            = 60;
  localparam int TURN_HALF             = 2;

  // (170 - mid) / 6 for mid in 0..150 as (x * 171) >> 10, exact over that range
  localparam int TURN_X_W         = 8;
  localparam int TURN_PROD_W      = 16;
  localparam int TURN_RECIP       = 171;
  localparam int TURN_RECIP_SHIFT = 10;
  localparam int TURN_P_W         = 5;

  localparam int PE_W = TURN_P_W + 1 + DIFF_W;
  localparam int DT_W = DGAIN_W + 1 + DELTA_W;

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  localparam logic [POS_W-1:0]   CENTER_RST   = 16'd1500;
  localparam logic [THR_W-1:0]   THRESH_RST   = 11'd200;
  localparam logic [DGAIN_W-1:0] DGAIN_RST    = 8'd5;
  localparam logic [POS_W-1:0]   RIGHT_RST    = 16'd1200;
  localparam logic [POS_W-1:0]   LEFT_RST     = 16'd1800;

  typedef enum logic [2:0] {
    REG_CENTER_POSITION      = 3'd0,
    REG_STRAIGHT_THRESHOLD   = 3'd1,
    REG_TURN_DERIVATIVE_GAIN = 3'd2,
    REG_RIGHT_LIMIT          = 3'd3,
    REG_LEFT_LIMIT           = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [POS_W-1:0]   center_position;
    logic [THR_W-1:0]   straight_threshold;
    logic [DGAIN_W-1:0] turn_derivative_gain;
    logic [POS_W-1:0]   right_limit;
    logic [POS_W-1:0]   left_limit;
  } cfg_t;

  typedef struct packed {
    logic [DIFF_W-1:0]   inner_diff;
    logic [DIFF_W-1:0]   outer_diff;
    logic [SUM_W-1:0]    inner_sum;
    logic                middle_high;
    logic                low_signal;
    logic [TURN_P_W-1:0] turn_gain;
  } item_t;

  typedef struct packed {
    logic [POS_W-1:0] steer_position;
    logic             straight_region;
    logic             held_previous;
    logic             limit_hit;
  } res_t;

endpackage

[design/drsc_cfg.sv]
// apb register file for the steering controller settings
`timescale 1ns / 1ps
module drsc_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [drsc_pkg::PADDR_W-1:0]  cfg_paddr,
  input  logic [drsc_pkg::PDATA_W-1:0]  cfg_pwdata,
  output logic [drsc_pkg::PDATA_W-1:0]  cfg_prdata,
  output logic                          cfg_pready,
  output drsc_pkg::cfg_t                cfg
);
  import drsc_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign cfg_pready = 1'b1;
  assign idx        = reg_idx_t'(cfg_paddr[PADDR_W-1:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_CENTER_POSITION:      cfg_nxt.center_position      = cfg_pwdata[POS_W-1:0];
        REG_STRAIGHT_THRESHOLD:   cfg_nxt.straight_threshold   = cfg_pwdata[THR_W-1:0];
        REG_TURN_DERIVATIVE_GAIN: cfg_nxt.turn_derivative_gain = cfg_pwdata[DGAIN_W-1:0];
        REG_RIGHT_LIMIT:          cfg_nxt.right_limit          = cfg_pwdata[POS_W-1:0];
        REG_LEFT_LIMIT:           cfg_nxt.left_limit           = cfg_pwdata[POS_W-1:0];
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CENTER_POSITION:      cfg_prdata = PDATA_W'(cfg_r.center_position);
      REG_STRAIGHT_THRESHOLD:   cfg_prdata = PDATA_W'(cfg_r.straight_threshold);
      REG_TURN_DERIVATIVE_GAIN: cfg_prdata = PDATA_W'(cfg_r.turn_derivative_gain);
      REG_RIGHT_LIMIT:          cfg_prdata = PDATA_W'(cfg_r.right_limit);
      REG_LEFT_LIMIT:           cfg_prdata = PDATA_W'(cfg_r.left_limit);
      default:                  cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_position      <= CENTER_RST;
      cfg_r.straight_threshold   <= THRESH_RST;
      cfg_r.turn_derivative_gain <= DGAIN_RST;
      cfg_r.right_limit          <= RIGHT_RST;
      cfg_r.left_limit           <= LEFT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[design/drsc_front.sv]
// input register with per-item differences, sum and turn gain
`timescale 1ns / 1ps
module drsc_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic [drsc_pkg::SENSOR_BITS-1:0] in_outer_left_level,
  input  logic [drsc_pkg::SENSOR_BITS-1:0] in_inner_left_level,
  input  logic [drsc_pkg::SENSOR_BITS-1:0] in_middle_level,
  input  logic [drsc_pkg::SENSOR_BITS-1:0] in_inner_right_level,
  input  logic [drsc_pkg::SENSOR_BITS-1:0] in_outer_right_level,
  output logic                             in_stall,
  input  logic                             take,
  output logic                             item_valid,
  output drsc_pkg::item_t                  item
);
  import drsc_pkg::*;

  logic                       valid_r, valid_nxt;
  item_t                      item_r, item_nxt;
  item_t                      pre;
  logic                       load;
  logic [TURN_X_W-1:0]        turn_x;
  logic [TURN_PROD_W-1:0]     turn_prod;

  assign in_stall   = valid_r && !take;
  assign load       = in_valid && !in_stall;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    pre.inner_diff  = DIFF_W'(in_inner_left_level) - DIFF_W'(in_inner_right_level);
    pre.outer_diff  = DIFF_W'(in_outer_left_level) - DIFF_W'(in_outer_right_level);
    pre.inner_sum   = SUM_W'(in_inner_left_level) + SUM_W'(in_inner_right_level);
    pre.middle_high = in_middle_level > SENSOR_BITS'(STRAIGHT_MIDDLE_LIMIT);
    pre.low_signal  = (in_inner_left_level < SENSOR_BITS'(WEAK_LEVEL))
                   && (in_middle_level < SENSOR_BITS'(WEAK_LEVEL));
    // gain only matters in the turn region, where middle is at most 150
    turn_x = pre.middle_high ? '0
           : TURN_X_W'(TURN_GAIN_BASE) - TURN_X_W'(in_middle_level);
    turn_prod = TURN_PROD_W'(turn_x) * TURN_PROD_W'(TURN_RECIP);
    pre.turn_gain = turn_prod[TURN_RECIP_SHIFT +: TURN_P_W];
  end

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (load) begin
      valid_nxt = 1'b1;
      item_nxt  = pre;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

endmodule

[design/drsc_core.sv]
// steering law, weak-signal hold, end-stop clamp and history registers
`timescale 1ns / 1ps
`include "dual_region_steering_controller_defines.svh"
module drsc_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            take,
  input  drsc_pkg::item_t item,
  input  drsc_pkg::cfg_t  cfg,
  output drsc_pkg::res_t  res
);
  import drsc_pkg::*;

  logic signed [DIFF_W-1:0]  last_inner_r, last_inner_nxt;
  logic signed [DIFF_W-1:0]  last_outer_r, last_outer_nxt;
  logic        [POS_W-1:0]   last_steer_r, last_steer_nxt;

  logic signed [DIFF_W-1:0]  ei, eo;
  logic signed [DELTA_W-1:0] di, dout;
  logic signed [PE_W-1:0]    pe, pe_half;
  logic signed [DT_W-1:0]    dterm;
  logic signed [VAL_W-1:0]   center_x, right_x, left_x;
  logic signed [VAL_W-1:0]   straight_val, turn_val, law_val, held_val, low_val, final_val;
  logic                      straight, hold, hit_low, hit_high;

  always_comb begin
    ei   = $signed(item.inner_diff);
    eo   = $signed(item.outer_diff);
    di   = DELTA_W'(ei) - DELTA_W'(last_inner_r);
    dout = DELTA_W'(eo) - DELTA_W'(last_outer_r);

    center_x = $signed(VAL_W'(cfg.center_position));
    right_x  = $signed(VAL_W'(cfg.right_limit));
    left_x   = $signed(VAL_W'(cfg.left_limit));

    straight = (CMP_W'(item.inner_sum) > CMP_W'(cfg.straight_threshold)) || item.middle_high;
    hold     = item.low_signal;

    straight_val = center_x + VAL_W'(STRAIGHT_P) * VAL_W'(ei) + VAL_W'(STRAIGHT_D) * VAL_W'(di);

    // halving truncates toward zero, as signed division does
    pe      = $signed(PE_W'(item.turn_gain)) * PE_W'(eo);
    pe_half = pe / PE_W'(TURN_HALF);
    dterm   = $signed(DT_W'(cfg.turn_derivative_gain)) * DT_W'(dout);
    turn_val = center_x + VAL_W'(pe_half) + VAL_W'(dterm);

    law_val  = straight ? straight_val : turn_val;
    held_val = $signed(VAL_W'(last_steer_r));

    // lower stop first, upper stop second: with crossed limits the left one wins
    hit_low   = (hold ? held_val : law_val) < right_x;
    low_val   = hit_low ? right_x : (hold ? held_val : law_val);
    hit_high  = low_val > left_x;
    final_val = hit_high ? left_x : low_val;

    res.steer_position  = final_val[POS_W-1:0];
    res.straight_region = straight;
    res.held_previous   = hold;
    res.limit_hit       = hit_low || hit_high;
  end

  always_comb begin
    last_inner_nxt = last_inner_r;
    last_outer_nxt = last_outer_r;
    last_steer_nxt = last_steer_r;
    if (take) begin
      last_inner_nxt = ei;
      last_outer_nxt = eo;
      last_steer_nxt = res.steer_position;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_inner_r <= '0;
      last_outer_r <= '0;
      last_steer_r <= '0;
    end else begin
      last_inner_r <= last_inner_nxt;
      last_outer_r <= last_outer_nxt;
      last_steer_r <= last_steer_nxt;
    end
  end

  `DRSC_ASSERT_IMPLIES(a_clamp_in_range, clk, rst_n, take && (cfg.right_limit <= cfg.left_limit), (res.steer_position >= cfg.right_limit) && (res.steer_position <= cfg.left_limit), "steering value outside end stops")
  `DRSC_ASSERT_IMPLIES(a_hit_at_stop, clk, rst_n, take && res.limit_hit, (res.steer_position == cfg.right_limit) || (res.steer_position == cfg.left_limit), "limit flag without value at an end stop")

endmodule

[design/dual_region_steering_controller.sv]
// top level of the dual region steering controller
// takes five sensor levels per item and returns one clamped steering value with
// three flags. straight gains (pd 6 and 5 on the inner difference) apply when the
// inner sum is above straight_threshold or the middle level is above 150, turn
// gains ((170 - middle) / 6 on the outer difference, halved, plus
// turn_derivative_gain on its change) otherwise; a weak signal repeats the last
// value, and the result is clamped between right_limit and left_limit. one item
// is accepted every cycle while out_stall does not hold a full result register;
// each item passes from an input register through the steering law in one pass
// into the result register.
// the history (last differences and last value) is updated in that same pass,
// so each item sees the one before it with no gap. the result register lets a
// new item be taken while a finished one waits on out_stall. the user must write
// settings over the apb port only while no item is in flight; the block does not enforce it.
`timescale 1ns / 1ps
`include "dual_region_steering_controller_defines.svh"
module dual_region_steering_controller (
  input  logic                             clk,
  input  logic                             rst_n,
  // sensor item in
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [drsc_pkg::SENSOR_BITS-1:0] in_outer_left_level,
  input  logic [drsc_pkg::SENSOR_BITS-1:0] in_inner_left_level,
  input  logic [drsc_pkg::SENSOR_BITS-1:0] in_middle_level,
  input  logic [drsc_pkg::SENSOR_BITS-1:0] in_inner_right_level,
  input  logic [drsc_pkg::SENSOR_BITS-1:0] in_outer_right_level,
  // steering item out
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [drsc_pkg::POS_W-1:0]       out_steer_position,
  output logic                             out_straight_region,
  output logic                             out_held_previous,
  output logic                             out_limit_hit,
  // settings
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [drsc_pkg::PADDR_W-1:0]     cfg_paddr,
  input  logic [drsc_pkg::PDATA_W-1:0]     cfg_pwdata,
  output logic [drsc_pkg::PDATA_W-1:0]     cfg_prdata,
  output logic                             cfg_pready
);
  import drsc_pkg::*;

  cfg_t  cfg;
  item_t item;
  res_t  res;
  res_t  res_r, res_nxt;
  logic  item_valid;
  logic  take;
  logic  out_valid_r, out_valid_nxt;

  // the item in the input register moves on when the result register is free
  // or is being emptied this cycle
  assign take = item_valid && (!out_valid_r || !out_stall);

  drsc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  drsc_front u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_outer_left_level  (in_outer_left_level),
    .in_inner_left_level  (in_inner_left_level),
    .in_middle_level      (in_middle_level),
    .in_inner_right_level (in_inner_right_level),
    .in_outer_right_level (in_outer_right_level),
    .in_stall             (in_stall),
    .take                 (take),
    .item_valid           (item_valid),
    .item                 (item)
  );

  drsc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .item  (item),
    .cfg   (cfg),
    .res   (res)
  );

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;
    if (take) begin
      out_valid_nxt = 1'b1;
      res_nxt       = res;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_steer_position  = res_r.steer_position;
  assign out_straight_region = res_r.straight_region;
  assign out_held_previous   = res_r.held_previous;
  assign out_limit_hit       = res_r.limit_hit;

  // input only backs up when both registers hold items and the sink is stalled
  `DRSC_ASSERT_IMPLIES(a_stall_only_when_full, clk, rst_n, in_stall, item_valid && out_valid_r && out_stall, "input stalled with room in the pipe")
  // an item leaving the input register lands in the result register
  `DRSC_ASSERT_NEXT(a_take_fills_result, clk, rst_n, take, out_valid_r, "item lost between registers")

endmodule

[test/tb_dual_region_steering_controller.sv]
`timescale 1ns / 1ps
// self-checking testbench for the dual region steering controller
module tb_dual_region_steering_controller;
  import drsc_pkg::*;

  localparam int LEVEL_MAX        = (1 << SENSOR_BITS) - 1;
  localparam int TURN_GAIN_DIV    = 6;
  localparam int N_REGS           = 5;
  localparam int N_PHASES         = 7;
  localparam int N_DIRECTED       = 16;
  localparam int RANDOM_PER_PHASE = 100;
  localparam int CHUNK            = 25;
  localparam int DRAIN_CYCLES     = 10;
  // first word address past the register map, writes there must be ignored
  localparam logic [PADDR_W-1:0] UNMAPPED_ADDR = 20;

  // one sensor set, in channel order
  typedef struct packed {
    logic [SENSOR_BITS-1:0] outer_left;
    logic [SENSOR_BITS-1:0] inner_left;
    logic [SENSOR_BITS-1:0] middle;
    logic [SENSOR_BITS-1:0] inner_right;
    logic [SENSOR_BITS-1:0] outer_right;
  } sensor_set_t;

  // directed row: levels, and a hand-typed result where one is obvious
  typedef struct packed {
    sensor_set_t levels;
    logic        typed;
    res_t        want;
  } directed_row_t;

  typedef struct packed {
    logic randomise;
    cfg_t values;
  } setting_plan_t;

  // columns: outer left, inner left, middle, inner right, outer right
  localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    // hold straight after reset: held zero is raised to the right stop
    '{'{0, 0, 0, 0, 0},                1'b1, '{16'd1200, 1'b0, 1'b1, 1'b1}},
    // all levels at full scale, balanced: straight, no correction
    '{'{1023, 1023, 1023, 1023, 1023}, 1'b1, '{16'd1500, 1'b1, 1'b0, 1'b0}},
    // inner left alone at full scale: pinned at the left stop
    '{'{0, 1023, 0, 0, 0},             1'b1, '{16'd1800, 1'b1, 1'b0, 1'b1}},
    // weak hold inside the straight region keeps the region flag
    '{'{0, 0, 0, 1023, 0},             1'b1, '{16'd1800, 1'b1, 1'b1, 1'b0}},
    // inner right at full scale, middle strong: pinned at the right stop
    '{'{0, 0, 200, 1023, 0},           1'b1, '{16'd1200, 1'b1, 1'b0, 1'b1}},
    // inner sum exactly on the threshold, middle on its limit: turn
    '{'{500, 100, 150, 100, 0},        1'b0, '0},
    // one above the threshold: straight
    '{'{500, 100, 150, 101, 0},        1'b0, '0},
    // straight on the middle level alone
    '{'{0, 60, 151, 0, 0},             1'b0, '0},
    // odd negative product, halving truncates toward zero
    '{'{0, 60, 149, 60, 1},            1'b0, '0},
    // largest turn gain, both outer extremes
    '{'{1023, 60, 0, 0, 0},            1'b0, '0},
    '{'{0, 60, 0, 0, 1023},            1'b0, '0},
    // weak-signal boundaries
    '{'{7, 59, 60, 3, 0},              1'b0, '0},
    '{'{7, 59, 59, 3, 0},              1'b0, '0},
    '{'{7, 60, 59, 3, 0},              1'b0, '0},
    '{'{1023, 60, 100, 60, 1023},      1'b0, '0},
    '{'{1023, 0, 0, 0, 1023},          1'b0, '0}
  };

  localparam setting_plan_t SETTING_PLAN [N_PHASES] = '{
    // everything at its floor, limits wide open
    '{1'b0, '{16'd0, 11'd0, 8'd0, 16'd0, 16'd65535}},
    // everything at its ceiling, limits wide open
    '{1'b0, '{16'd65535, 11'd2047, 8'd255, 16'd0, 16'd65535}},
    // crossed limits, the left stop wins
    '{1'b0, '{16'd1500, 11'd200, 8'd5, 16'd2000, 16'd1000}},
    '{1'b0, '{16'd1500, 11'd300, 8'd12, 16'd1000, 16'd2000}},
    '{1'b1, '0},
    // both stops on the same value
    '{1'b0, '{16'd32768, 11'd1023, 8'd128, 16'd30000, 16'd30000}},
    '{1'b1, '0}
  };

  logic                   clk;
  logic                   rst_n                = 1'b0;
  logic                   in_valid             = 1'b0;
  logic                   in_stall;
  logic [SENSOR_BITS-1:0] in_outer_left_level  = '0;
  logic [SENSOR_BITS-1:0] in_inner_left_level  = '0;
  logic [SENSOR_BITS-1:0] in_middle_level      = '0;
  logic [SENSOR_BITS-1:0] in_inner_right_level = '0;
  logic [SENSOR_BITS-1:0] in_outer_right_level = '0;
  logic                   out_valid;
  logic                   out_stall            = 1'b0;
  logic [POS_W-1:0]       out_steer_position;
  logic                   out_straight_region;
  logic                   out_held_previous;
  logic                   out_limit_hit;
  logic                   cfg_psel             = 1'b0;
  logic                   cfg_penable          = 1'b0;
  logic                   cfg_pwrite           = 1'b0;
  logic [PADDR_W-1:0]     cfg_paddr            = '0;
  logic [PDATA_W-1:0]     cfg_pwdata           = '0;
  logic [PDATA_W-1:0]     cfg_prdata;
  logic                   cfg_pready;

  // predictor copy of the settings and the history
  cfg_t                     setting;
  logic signed [DIFF_W-1:0] prev_inner_diff;
  logic signed [DIFF_W-1:0] prev_outer_diff;
  logic [POS_W-1:0]         prev_steer;

  res_t pending_steer[$];
  int   failures  = 0;
  bit   in_quiet  = 1'b0;
  bit   out_quiet = 1'b0;

  dual_region_steering_controller i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_outer_left_level (in_outer_left_level),
    .in_inner_left_level (in_inner_left_level),
    .in_middle_level     (in_middle_level),
    .in_inner_right_level(in_inner_right_level),
    .in_outer_right_level(in_outer_right_level),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_steer_position  (out_steer_position),
    .out_straight_region (out_straight_region),
    .out_held_previous   (out_held_previous),
    .out_limit_hit       (out_limit_hit),
    .cfg_psel            (cfg_psel),
    .cfg_penable         (cfg_penable),
    .cfg_pwrite          (cfg_pwrite),
    .cfg_paddr           (cfg_paddr),
    .cfg_pwdata          (cfg_pwdata),
    .cfg_prdata          (cfg_prdata),
    .cfg_pready          (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [PADDR_W-1:0] reg_addr(input reg_idx_t r);
    return {r, 2'b00};
  endfunction

  function automatic logic [PDATA_W-1:0] field_of(input cfg_t c, input reg_idx_t r);
    case (r)
      REG_CENTER_POSITION:      return PDATA_W'(c.center_position);
      REG_STRAIGHT_THRESHOLD:   return PDATA_W'(c.straight_threshold);
      REG_TURN_DERIVATIVE_GAIN: return PDATA_W'(c.turn_derivative_gain);
      REG_RIGHT_LIMIT:          return PDATA_W'(c.right_limit);
      REG_LEFT_LIMIT:           return PDATA_W'(c.left_limit);
      default:                  return '0;
    endcase
  endfunction

  // register write as the block sees it: masked to width, unmapped ignored
  function automatic void apply_setting(input logic [PADDR_W-1:0] addr,
                                        input logic [PDATA_W-1:0] data);
    case (addr)
      reg_addr(REG_CENTER_POSITION):      setting.center_position      = data[POS_W-1:0];
      reg_addr(REG_STRAIGHT_THRESHOLD):   setting.straight_threshold   = data[THR_W-1:0];
      reg_addr(REG_TURN_DERIVATIVE_GAIN): setting.turn_derivative_gain = data[DGAIN_W-1:0];
      reg_addr(REG_RIGHT_LIMIT):          setting.right_limit          = data[POS_W-1:0];
      reg_addr(REG_LEFT_LIMIT):           setting.left_limit           = data[POS_W-1:0];
      default: ;
    endcase
  endfunction

  // steering law for one sensor set, advancing the history
  function automatic res_t steer_law(input sensor_set_t s);
    longint ol, il, mid, ir, orr;
    longint inner_diff, outer_diff, gain, steer, lo, hi;
    logic   straight, hold, hit;
    res_t   r;
    ol  = longint'(s.outer_left);
    il  = longint'(s.inner_left);
    mid = longint'(s.middle);
    ir  = longint'(s.inner_right);
    orr = longint'(s.outer_right);
    inner_diff = il - ir;
    outer_diff = ol - orr;
    steer = longint'(setting.center_position);
    straight = (il + ir > longint'(setting.straight_threshold)) ||
               (mid > longint'(STRAIGHT_MIDDLE_LIMIT));
    if (straight) begin
      steer = steer + longint'(STRAIGHT_P) * inner_diff
            + longint'(STRAIGHT_D) * (inner_diff - longint'(prev_inner_diff));
    end else begin
      // signed division truncates toward zero, as the control law expects
      gain  = (longint'(TURN_GAIN_BASE) - mid) / longint'(TURN_GAIN_DIV);
      steer = steer + (gain * outer_diff) / longint'(TURN_HALF)
            + longint'(setting.turn_derivative_gain) * (outer_diff - longint'(prev_outer_diff));
    end
    hold = (il < longint'(WEAK_LEVEL)) && (mid < longint'(WEAK_LEVEL));
    if (hold) steer = longint'(prev_steer);
    // lower stop first, so the left stop wins when the two are crossed
    lo  = longint'(setting.right_limit);
    hi  = longint'(setting.left_limit);
    hit = 1'b0;
    if (steer < lo) begin
      steer = lo;
      hit   = 1'b1;
    end
    if (steer > hi) begin
      steer = hi;
      hit   = 1'b1;
    end
    prev_inner_diff = inner_diff[DIFF_W-1:0];
    prev_outer_diff = outer_diff[DIFF_W-1:0];
    prev_steer      = steer[POS_W-1:0];
    r.steer_position  = steer[POS_W-1:0];
    r.straight_region = straight;
    r.held_previous   = hold;
    r.limit_hit       = hit;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  // mostly no gap, some short ones, a few long ones
  function automatic int idle_span(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int clip_level(input int v);
    if (v < 0) return 0;
    if (v > LEVEL_MAX) return LEVEL_MAX;
    return v;
  endfunction

  // random sets biased toward the turn region, the weak hold and the edges
  function automatic sensor_set_t random_levels();
    sensor_set_t s;
    int          pick, room;
    s.outer_left  = SENSOR_BITS'($urandom_range(0, LEVEL_MAX));
    s.inner_left  = SENSOR_BITS'($urandom_range(0, LEVEL_MAX));
    s.middle      = SENSOR_BITS'($urandom_range(0, LEVEL_MAX));
    s.inner_right = SENSOR_BITS'($urandom_range(0, LEVEL_MAX));
    s.outer_right = SENSOR_BITS'($urandom_range(0, LEVEL_MAX));
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      // turn region: inner sum within the threshold, middle not above its limit
      room = clip_level(int'(setting.straight_threshold));
      s.inner_left = SENSOR_BITS'($urandom_range(0, room));
      room = clip_level(int'(setting.straight_threshold) - int'(s.inner_left));
      s.inner_right = SENSOR_BITS'($urandom_range(0, room));
      s.middle = SENSOR_BITS'($urandom_range(0, STRAIGHT_MIDDLE_LIMIT));
      if ($urandom_range(0, 1))
        s.outer_right = SENSOR_BITS'(clip_level(int'(s.outer_left)
                                                + int'($urandom_range(0, 40)) - 20));
    end else if (pick < 55) begin
      s.inner_left = SENSOR_BITS'($urandom_range(0, WEAK_LEVEL - 1));
      s.middle     = SENSOR_BITS'($urandom_range(0, WEAK_LEVEL - 1));
    end else if (pick < 70) begin
      // one step either side of the region and hold decisions
      if ($urandom_range(0, 1))
        s.middle = SENSOR_BITS'(STRAIGHT_MIDDLE_LIMIT - 1 + int'($urandom_range(0, 2)));
      else
        s.middle = SENSOR_BITS'(WEAK_LEVEL - 1 + int'($urandom_range(0, 1)));
      s.inner_left  = SENSOR_BITS'(WEAK_LEVEL - 1 + int'($urandom_range(0, 1)));
      s.inner_right = SENSOR_BITS'(clip_level(int'(setting.straight_threshold)
                                              - int'(s.inner_left)
                                              + int'($urandom_range(0, 2)) - 1));
    end
    return s;
  endfunction

  task automatic put_levels(input sensor_set_t s);
    in_outer_left_level  <= s.outer_left;
    in_inner_left_level  <= s.inner_left;
    in_middle_level      <= s.middle;
    in_inner_right_level <= s.inner_right;
    in_outer_right_level <= s.outer_right;
  endtask

  // offer one item, wait for it to be taken, then idle for the gap
  task automatic send_item(input sensor_set_t s, input logic typed, input res_t want,
                           input int gap);
    res_t predicted;
    put_levels(s);
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predicted = steer_law(s);
    pending_steer.push_back(typed ? want : predicted);
    if (gap > 0) begin
      in_valid <= 1'b0;
      put_levels(random_levels());
      repeat (gap) @(posedge clk);
    end
  endtask

  // ---------------------------------------------------------------- settings port

  task automatic cfg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    apply_setting(addr, data);
    @(posedge clk);
  endtask

  // read data is sampled mid-cycle in the access phase
  task automatic cfg_read(input logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
    logic ready;
    cfg_psel   <= 1'b1;
    cfg_pwrite <= 1'b0;
    cfg_paddr  <= addr;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do begin
      @(negedge clk);
      data  = cfg_prdata;
      ready = cfg_pready;
      @(posedge clk);
    end while (!ready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_settings();
    logic [PDATA_W-1:0] got, due;
    reg_idx_t           r;
    for (int i = 0; i < N_REGS; i++) begin
      r   = reg_idx_t'(i);
      due = field_of(setting, r);
      cfg_read(reg_addr(r), got);
      if (got !== due) begin
        $error("register %s: expected %0d, got %0d", r.name(), due, got);
        failures++;
      end
    end
  endtask

  // let every item in flight come out before the settings move
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_steer.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- result side

  // back-pressure on the result side, with quiet stretches
  initial begin
    int span;
    @(posedge clk);
    forever begin
      span = idle_span(out_quiet);
      if (span > 0) begin
        out_stall <= 1'b1;
        repeat (span) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    res_t due;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_steer.size() == 0) begin
        $error("steering item with nothing pending: steer_position %0d",
               out_steer_position);
        failures++;
      end else begin
        due = pending_steer.pop_front();
        if (out_steer_position !== due.steer_position) begin
          $error("steer_position: expected %0d, got %0d",
                 due.steer_position, out_steer_position);
          failures++;
        end
        if (out_straight_region !== due.straight_region) begin
          $error("straight_region: expected %0d, got %0d",
                 due.straight_region, out_straight_region);
          failures++;
        end
        if (out_held_previous !== due.held_previous) begin
          $error("held_previous: expected %0d, got %0d",
                 due.held_previous, out_held_previous);
          failures++;
        end
        if (out_limit_hit !== due.limit_hit) begin
          $error("limit_hit: expected %0d, got %0d", due.limit_hit, out_limit_hit);
          failures++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    cfg_t               plan;
    logic [PDATA_W-1:0] data;
    int                 centre;
    setting         = '{CENTER_RST, THRESH_RST, DGAIN_RST, RIGHT_RST, LEFT_RST};
    prev_inner_diff = '0;
    prev_outer_diff = '0;
    prev_steer      = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values first, then the directed rows under them
    check_settings();
    for (int i = 0; i < N_DIRECTED; i++)
      send_item(DIRECTED_ROWS[i].levels, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want,
                idle_span(1'b0));

    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle();
      plan = SETTING_PLAN[ph].values;
      if (SETTING_PLAN[ph].randomise) begin
        // stops placed around the centre so that not every item is pinned
        centre                    = $urandom_range(2000, 63000);
        plan.center_position      = POS_W'(centre);
        plan.straight_threshold   = THR_W'($urandom_range(0, 2047));
        plan.turn_derivative_gain = DGAIN_W'($urandom_range(0, 255));
        plan.right_limit          = POS_W'(centre - int'($urandom_range(0, 1500)));
        plan.left_limit           = POS_W'(centre + int'($urandom_range(0, 1500)));
      end
      for (int i = 0; i < N_REGS; i++) begin
        data = field_of(plan, reg_idx_t'(i));
        // junk above the register width must be dropped
        if (SETTING_PLAN[ph].randomise)
          data[PDATA_W-1:POS_W] = POS_W'($urandom_range(0, 65535));
        cfg_write(reg_addr(reg_idx_t'(i)), data);
      end
      cfg_write(UNMAPPED_ADDR, $urandom());
      check_settings();

      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (n % CHUNK == 0) begin
          in_quiet  = ($urandom_range(0, 3) == 0);
          out_quiet = ($urandom_range(0, 3) == 0);
        end
        send_item(random_levels(), 1'b0, '0, idle_span(in_quiet));
      end
    end

    settle();
    if (failures == 0)
      $display("dual_region_steering_controller verification clean");
    else
      $display("dual_region_steering_controller verification failed");
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #2000000;
    $display("dual_region_steering_controller verification failed");
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/drsc_pkg.sv
design/drsc_cfg.sv
design/drsc_front.sv
design/drsc_core.sv
design/dual_region_steering_controller.sv
test/tb_dual_region_steering_controller.sv
